>>> src/ljs_pkg.sv
package ljs_pkg;

    localparam int TIME_BITS_DEF  = 48;
    localparam int COUNT_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int LAT_BITS   = 31;
    localparam int MEAN_BITS  = 39;
    localparam int M2_BITS    = 64;
    localparam int WARM_BITS  = 8;
    localparam logic [WARM_BITS-1:0] WARMUP_RESET = 8'd5;

    // per-channel results handed from the stats unit to the top level
    typedef struct packed {
        logic [LAT_BITS-1:0]  max_lat;
        logic [MEAN_BITS-1:0] mean;
        logic [MEAN_BITS-1:0] dev;
        logic [MEAN_BITS-1:0] max_dev;
    } t_chan_out;

    // start/restart controls from sequencer to stats unit
    typedef struct packed {
        logic start;
        logic restart;
    } t_chan_ctl;

endpackage

>>> src/ljs_chan.sv
module ljs_chan #(
    parameter int COUNT_BITS = ljs_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ljs_pkg::t_chan_ctl            i_ctl,
    input  logic [ljs_pkg::LAT_BITS-1:0]  i_lat,
    input  logic [COUNT_BITS-1:0]         i_k,
    output logic                          o_done,
    output ljs_pkg::t_chan_out            o_res
);
    localparam int MB = ljs_pkg::MEAN_BITS;
    localparam int WB = ljs_pkg::M2_BITS;
    localparam int CB = COUNT_BITS;
    localparam int FB = ljs_pkg::FRAC_BITS_DEF;
    // bit-serial work unit: divide d1/k, multiply d1*d2, divide m2/(k-1), sqrt
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV1 = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV2 = 3'd3;
    localparam logic [2:0] S_SQRT = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]  r_st, n_st;
    logic [6:0]  r_cnt, n_cnt;
    logic [ljs_pkg::LAT_BITS-1:0] r_peak, n_peak;
    logic [MB-1:0] r_mean, n_mean, r_jpk, n_jpk, r_dev, n_dev;
    logic [WB-1:0] r_m2, n_m2;
    logic          r_ge, n_ge;
    logic [WB-1:0] r_a, n_a;     // dividend/quotient, multiplier, sqrt radicand
    logic [WB:0]   r_rem, n_rem; // remainder, product accumulator
    logic [WB-1:0] r_b, n_b;     // multiplicand / sqrt result
    logic          r_ovf, n_ovf;
    logic [CB-1:0] r_div, n_div;
    logic [MB:0]   xs;
    logic [WB:0]   rs, trial;
    logic [WB:0]   sum;

    always_comb begin
        xs = {{(MB+1-ljs_pkg::LAT_BITS-FB){1'b0}}, i_lat, {FB{1'b0}}};
        n_st = r_st; n_cnt = r_cnt; n_peak = r_peak; n_mean = r_mean; n_jpk = r_jpk;
        n_dev = r_dev; n_m2 = r_m2; n_ge = r_ge; n_a = r_a; n_rem = r_rem; n_b = r_b;
        n_ovf = r_ovf; n_div = r_div;
        rs = '0; trial = '0; sum = '0;
        unique case (r_st)
            S_IDLE: begin
                // count full: mean and m2 restart once the result is taken
                if (i_ctl.restart) begin
                    n_mean = '0; n_m2 = '0;
                end
                if (i_ctl.start) begin
                    if (i_lat > r_peak) n_peak = i_lat;
                    n_ge = xs >= {1'b0, r_mean};
                    n_a = (xs >= {1'b0, r_mean})
                        ? {{(WB-MB-1){1'b0}}, xs - {1'b0, r_mean}}
                        : {{(WB-MB-1){1'b0}}, {1'b0, r_mean} - xs};
                    n_rem = '0; n_div = i_k; n_cnt = 7'(MB); n_st = S_DIV1;
                end
            end
            S_DIV1: begin
                // restoring division, one quotient bit per cycle over MB bits
                rs = {r_rem[WB-1:0], r_a[MB-1]};
                if (rs >= {{(WB+1-CB){1'b0}}, r_div}) begin
                    rs = rs - {{(WB+1-CB){1'b0}}, r_div};
                    n_a = {r_a[WB-2:0], 1'b1};
                end else begin
                    n_a = {r_a[WB-2:0], 1'b0};
                end
                n_rem = rs;
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    // n_a[MB-1:0] is floor(d1/k); rebuild d1 from old mean
                    if (r_ge) begin
                        n_mean = r_mean + n_a[MB-1:0];
                        n_b = {{(WB-MB-1){1'b0}}, xs - {1'b0, r_mean}};
                        n_a = {{(WB-MB-1){1'b0}}, xs - {1'b0, n_mean}};
                    end else begin
                        n_mean = r_mean - n_a[MB-1:0];
                        n_b = {{(WB-MB-1){1'b0}}, {1'b0, r_mean} - xs};
                        n_a = {{(WB-MB-1){1'b0}}, {1'b0, n_mean} - xs};
                    end
                    n_rem = '0; n_ovf = 1'b0; n_cnt = 7'(MB+1); n_st = S_MUL;
                end
            end
            S_MUL: begin
                // msb-first shift-add, a bit of d2 per cycle, overflow sticky
                if (r_rem[WB] || r_rem[WB-1]) n_ovf = 1'b1;
                rs = {r_rem[WB-1:0], 1'b0};
                if (r_a[MB]) rs = rs + {1'b0, r_b};
                if (rs[WB]) n_ovf = 1'b1;
                n_rem = {1'b0, rs[WB-1:0]};
                n_a = {r_a[WB-2:0], 1'b0};
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    sum = {1'b0, r_m2} + {1'b0, rs[WB-1:0]};
                    n_m2 = (n_ovf || sum[WB]) ? {WB{1'b1}} : sum[WB-1:0];
                    n_a = n_m2; n_rem = '0;
                    n_div = i_k - CB'(1);
                    n_cnt = 7'(WB);
                    n_st = (i_k > CB'(1)) ? S_DIV2 : S_FIN;
                    n_dev = '0;
                end
            end
            S_DIV2: begin
                rs = {r_rem[WB-1:0], r_a[WB-1]};
                if (rs >= {{(WB+1-CB){1'b0}}, r_div}) begin
                    rs = rs - {{(WB+1-CB){1'b0}}, r_div};
                    n_a = {r_a[WB-2:0], 1'b1};
                end else begin
                    n_a = {r_a[WB-2:0], 1'b0};
                end
                n_rem = rs;
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    n_rem = '0; n_b = '0; n_cnt = 7'(WB/2); n_st = S_SQRT;
                end
            end
            S_SQRT: begin
                // digit-by-digit root, two radicand bits per cycle
                rs = {r_rem[WB-2:0], r_a[WB-1:WB-2]};
                trial = {r_b[WB-2:0], 2'b01};
                if (rs >= trial) begin
                    n_rem = rs - trial;
                    n_b = {r_b[WB-2:0], 1'b1};
                end else begin
                    n_rem = rs;
                    n_b = {r_b[WB-2:0], 1'b0};
                end
                n_a = {r_a[WB-3:0], 2'b00};
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    n_dev = n_b[MB-1:0];
                    n_st = S_FIN;
                end
            end
            S_FIN: begin
                if (r_dev > r_jpk) n_jpk = r_dev;
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_peak <= '0; r_mean <= '0; r_m2 <= '0; r_jpk <= '0;
        end else begin
            r_st <= n_st; r_peak <= n_peak; r_mean <= n_mean; r_m2 <= n_m2;
            r_jpk <= n_jpk;
        end
        r_cnt <= n_cnt; r_dev <= n_dev; r_ge <= n_ge; r_a <= n_a; r_rem <= n_rem;
        r_b <= n_b; r_ovf <= n_ovf; r_div <= n_div;
    end

    assign o_done = (r_st == S_FIN);
    always_comb begin
        o_res.max_lat = r_peak;
        o_res.mean    = r_mean;
        o_res.dev     = r_dev;
        o_res.max_dev = (r_dev > r_jpk) ? r_dev : r_jpk;
    end
endmodule

>>> src/latency_jitter_statistics_top.sv
// channel   dir  handshake       payload
// in        in   valid / stall   start_time, end_time, loop_start_time
// out       out  valid / stall   task_* (4), cycle_period, loop_* (4)
// cfg       in   valid / ready   warmup_count
// a record goes through these steps from its accept to the next accept: take it,
//   start, mean divide, multiply, deviation divide, root, finish, load the output
//   (which waits while a held result is stalled); the result shows once loaded
// with k = 1 the deviation divide and root are skipped
// warm-up records are taken but give no result
// reset is synchronous; state, counters and output valid restart at zero, warmup_count at 5
// a waiting result holds in the output register; the next record is taken
//   while it waits, but its result waits for the register to drain
module latency_jitter_statistics_top #(
    parameter int TIME_BITS  = ljs_pkg::TIME_BITS_DEF,
    parameter int COUNT_BITS = ljs_pkg::COUNT_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [TIME_BITS-1:0]               i_start_time,
    input  logic [TIME_BITS-1:0]               i_end_time,
    input  logic [TIME_BITS-1:0]               i_loop_start_time,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [ljs_pkg::LAT_BITS-1:0]       o_task_max_latency,
    output logic [ljs_pkg::MEAN_BITS-1:0]      o_task_mean_latency,
    output logic [ljs_pkg::MEAN_BITS-1:0]      o_task_std_jitter,
    output logic [ljs_pkg::MEAN_BITS-1:0]      o_task_max_jitter,
    output logic [TIME_BITS-1:0]               o_cycle_period,
    output logic [ljs_pkg::LAT_BITS-1:0]       o_loop_max_latency,
    output logic [ljs_pkg::MEAN_BITS-1:0]      o_loop_mean_latency,
    output logic [ljs_pkg::MEAN_BITS-1:0]      o_loop_std_jitter,
    output logic [ljs_pkg::MEAN_BITS-1:0]      o_loop_max_jitter,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ljs_pkg::WARM_BITS-1:0]      i_cfg_data
);
    localparam int LB = ljs_pkg::LAT_BITS;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0] r_st;
    logic [ljs_pkg::WARM_BITS-1:0] r_wcfg, r_wseen;
    logic [COUNT_BITS-1:0] r_k;
    logic [TIME_BITS-1:0]  r_prev, r_per, r_st_t, r_et, r_lt;
    logic [LB-1:0] task_lat, loop_lat;
    logic [TIME_BITS-1:0] dt, dl;
    logic r_ovalid;
    logic r_hold_run;
    logic t_done, l_done;
    ljs_pkg::t_chan_ctl ctl;
    ljs_pkg::t_chan_out t_res, l_res;
    logic acc, restart, out_load;

    assign o_cfg_ready = 1'b1;
    assign o_stall = (r_st != S_IDLE);
    assign acc = i_valid && !o_stall;
    assign restart = (r_k == {COUNT_BITS{1'b1}});
    assign out_load = (r_st == S_HOLD) && (!r_ovalid || !i_stall);

    assign dt = r_et - r_st_t;
    assign dl = r_et - r_lt;
    assign task_lat = (dt > TIME_BITS'({LB{1'b1}})) ? {LB{1'b1}} : dt[LB-1:0];
    assign loop_lat = (dl > TIME_BITS'({LB{1'b1}})) ? {LB{1'b1}} : dl[LB-1:0];
    assign ctl.start = (r_st == S_RUN) && !t_done && (r_k != '0) && !r_hold_run;
    assign ctl.restart = out_load && restart;

    ljs_chan #(.COUNT_BITS(COUNT_BITS)) u_task (
        .i_clk, .i_rst_n, .i_ctl(ctl), .i_lat(task_lat), .i_k(r_k),
        .o_done(t_done), .o_res(t_res));
    ljs_chan #(.COUNT_BITS(COUNT_BITS)) u_loop (
        .i_clk, .i_rst_n, .i_ctl(ctl), .i_lat(loop_lat), .i_k(r_k),
        .o_done(l_done), .o_res(l_res));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_wcfg <= ljs_pkg::WARMUP_RESET; r_wseen <= '0;
            r_k <= '0; r_prev <= '0; r_ovalid <= 1'b0; r_hold_run <= 1'b0;
        end else begin
            if (i_cfg_valid) r_wcfg <= i_cfg_data;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (acc) begin
                        r_prev <= i_start_time;
                        if (r_wseen < r_wcfg) begin
                            r_wseen <= r_wseen + 1'b1;
                        end else begin
                            r_st_t <= i_start_time; r_et <= i_end_time;
                            r_lt <= i_loop_start_time;
                            r_per <= i_start_time - r_prev;
                            r_k <= r_k + 1'b1;
                            r_hold_run <= 1'b0;
                            r_st <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    r_hold_run <= 1'b1;
                    if (t_done && l_done) r_st <= S_HOLD;
                end
                S_HOLD: begin
                    // wait for the output register to be free
                    if (out_load) begin
                        o_task_max_latency <= t_res.max_lat;
                        o_task_mean_latency <= t_res.mean;
                        o_task_std_jitter <= t_res.dev;
                        o_task_max_jitter <= t_res.max_dev;
                        o_cycle_period <= r_per;
                        o_loop_max_latency <= l_res.max_lat;
                        o_loop_mean_latency <= l_res.mean;
                        o_loop_std_jitter <= l_res.dev;
                        o_loop_max_jitter <= l_res.max_dev;
                        if (restart) begin
                            r_k <= '0; r_wseen <= '0;
                        end
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
endmodule

>>> src/ljs_check.sv
module ljs_check #(
    parameter int TIME_BITS = ljs_pkg::TIME_BITS_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic [TIME_BITS-1:0] o_cycle_period
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cycle_period))
        else $error("output changed while stalled");
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("not idle after reset");
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> !o_valid || $past(o_valid))
        else $error("result in the cycle after accept");
endmodule

bind latency_jitter_statistics_top ljs_check #(.TIME_BITS(TIME_BITS)) u_chk (
    .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
    .o_cycle_period(o_cycle_period));
